// File: hw/rtl/mssp_pkg.sv
// ----------------------------------------------------------------------------
// mssp_pkg
// Shared types, command codes and ramp helpers of the motor speed step planner.
// ----------------------------------------------------------------------------
package mssp_pkg;

  localparam int MAX_STEPS  = 4;
  localparam int STEP_IDX_W = $clog2(MAX_STEPS);
  localparam int STEP_CNT_W = $clog2(MAX_STEPS + 1);

  // Command codes
  localparam logic [4:0] CMD_STOP       = 5'd0;
  localparam logic [4:0] CMD_FWD        = 5'd1;
  localparam logic [4:0] CMD_FWD_SLOW   = 5'd2;
  localparam logic [4:0] CMD_BACK       = 5'd3;
  localparam logic [4:0] CMD_FWD_L      = 5'd4;
  localparam logic [4:0] CMD_FWD_R      = 5'd5;
  localparam logic [4:0] CMD_BACK_L     = 5'd6;
  localparam logic [4:0] CMD_BACK_R     = 5'd7;
  localparam logic [4:0] CMD_TURN_L     = 5'd8;
  localparam logic [4:0] CMD_TURN_R     = 5'd9;
  localparam logic [4:0] CMD_TREV_L     = 5'd10;
  localparam logic [4:0] CMD_TREV_R     = 5'd11;
  localparam logic [4:0] CMD_ROT_L      = 5'd12;
  localparam logic [4:0] CMD_ROT_R      = 5'd13;
  localparam logic [4:0] CMD_UT_L       = 5'd14;
  localparam logic [4:0] CMD_UT_R       = 5'd15;

  // Configuration register indexes
  localparam logic [1:0] REG_MIN_SPEED  = 2'd0;
  localparam logic [1:0] REG_MAX_SPEED  = 2'd1;
  localparam logic [1:0] REG_UTURN_BASE = 2'd2;

  localparam logic [15:0] ESTOP_HOLD = 16'd20;
  // ceil(2^29 / 100): exact floor(x / 100) for x below 2^22
  localparam logic [22:0] RECIP100   = 23'd5368710;
  localparam int          RECIP_SH   = 29;

  typedef struct packed {
    logic [MAX_STEPS-1:0][8:0] spd;
    logic [STEP_CNT_W-1:0]     cnt;
  } plan_t;

  typedef struct packed {
    logic [4:0]  cmd;
    plan_t       lp;
    plan_t       rp;
    logic [15:0] hold;
    logic        imm;
    logic        last;
  } move_t;

  // floor(x / 3) for an 8-bit magnitude
  function automatic logic [7:0] div3(input logic [7:0] x);
    logic [16:0] prod;
    prod = 17'(x) * 17'd171;
    return prod[16:9];
  endfunction

  function automatic plan_t add_step(input plan_t p, input logic signed [9:0] v);
    plan_t r;
    r = p;
    r.spd[p.cnt[STEP_IDX_W-1:0]] = v[8:0];
    r.cnt = p.cnt + STEP_CNT_W'(1);
    return r;
  endfunction

  // Ramp from cur to nw passing -m, 0 and +m
  function automatic plan_t plan_ramp(input logic signed [8:0] cur,
                                      input logic signed [8:0] nw,
                                      input logic [7:0] m);
    plan_t p;
    logic signed [9:0] c;
    logic signed [9:0] n;
    logic signed [9:0] mp;
    logic signed [9:0] mn;
    p  = '0;
    c  = {cur[8], cur};
    n  = {nw[8], nw};
    mp = $signed({2'b00, m});
    mn = -mp;
    if (n > c) begin
      if (n <= mn) begin
        p = add_step(p, n);
      end else begin
        if (c < mn) p = add_step(p, mn);
        if (c < 10'sd0) p = add_step(p, 10'sd0);
        if (n != 10'sd0) begin
          if (c < mp) p = add_step(p, mp);
          if (n != mp) p = add_step(p, n);
        end
      end
    end else if (n < c) begin
      if (n >= mp) begin
        p = add_step(p, n);
      end else begin
        if (c > mp) p = add_step(p, mp);
        if (c > 10'sd0) p = add_step(p, 10'sd0);
        if (n != 10'sd0) begin
          if (c > mn) p = add_step(p, mn);
          if (n != mn) p = add_step(p, n);
        end
      end
    end else begin
      p = add_step(p, n);
    end
    return p;
  endfunction

endpackage

// File: hw/rtl/mssp_front.sv
// ----------------------------------------------------------------------------
// mssp_front
// Accepts commands, derives speeds and U-turn hold, plans the motor ramps and
// pushes one or two moves per known command into the move queue.
// ----------------------------------------------------------------------------
module mssp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         min_speed_i,
  input  logic [7:0]         max_speed_i,
  input  logic [11:0]        uturn_base_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               func_i,
  input  logic [4:0]         drive_command_i,
  input  logic signed [10:0] tick_percent_i,
  input  logic [4:0]         running_command_i,
  input  logic               full_i,
  output logic               push_o,
  output mssp_pkg::move_t    move_o
);
  import mssp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL   = 5'b00010,
    S_DIV   = 5'b00100,
    S_PLAN  = 5'b01000,
    S_PLAN2 = 5'b10000
  } fe_state_e;

  fe_state_e state_q, state_d;

  logic               func_q;
  logic [4:0]         cmd_q;
  logic signed [10:0] pct_q;
  logic [4:0]         run_q;
  logic signed [23:0] prod_q;
  logic [15:0]        quo_q;
  logic               neg_q;
  logic signed [8:0]  slow_q, smax_q, sslow_q;
  logic signed [8:0]  lt_q, lt_d, rt_q, rt_d;

  logic               accept, done;
  logic signed [23:0] prod_d;
  logic [22:0]        pmag;
  logic [45:0]        recip_prod;
  logic signed [9:0]  diff;
  logic [7:0]         dmag;
  logic [7:0]         d3, d2, d23;
  logic signed [9:0]  slow_d, smax_d, sslow_d;
  logic signed [17:0] ut_s, quo_s;
  logic [15:0]        ut_hold;
  logic signed [8:0]  mx_s;
  logic signed [8:0]  tl, tr;
  logic [4:0]         tcmd;
  logic               known, uturn, backing;

  // Speed derivation and U-turn product, taken in S_MUL
  always_comb begin
    diff    = $signed({2'b00, max_speed_i}) - $signed({2'b00, min_speed_i});
    dmag    = diff[9] ? 8'(-diff) : diff[7:0];
    d3      = div3(dmag);
    d2      = dmag >> 1;
    d23     = div3(d2);
    slow_d  = diff[9] ? $signed({2'b00, min_speed_i}) - $signed({2'b00, d3})
                      : $signed({2'b00, min_speed_i}) + $signed({2'b00, d3});
    smax_d  = diff[9] ? $signed({2'b00, min_speed_i}) - $signed({2'b00, d2})
                      : $signed({2'b00, min_speed_i}) + $signed({2'b00, d2});
    sslow_d = diff[9] ? $signed({2'b00, min_speed_i}) - $signed({2'b00, d23})
                      : $signed({2'b00, min_speed_i}) + $signed({2'b00, d23});
    prod_d  = 24'($signed({1'b0, uturn_base_i})) * 24'(pct_q);
  end

  // Division by 100 as a reciprocal multiply, taken in S_DIV
  always_comb begin
    pmag       = prod_q[23] ? 23'(-prod_q) : prod_q[22:0];
    recip_prod = 46'(pmag) * 46'(RECIP100);
  end

  always_comb begin
    quo_s   = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
    ut_s    = $signed({6'b0, uturn_base_i}) + quo_s;
    ut_hold = ut_s[17] ? 16'd0 : ut_s[15:0];
  end

  // Command decode to signed targets
  always_comb begin
    mx_s    = $signed({1'b0, max_speed_i});
    backing = (run_q == CMD_BACK) || (run_q == CMD_BACK_L) || (run_q == CMD_BACK_R);
    known   = 1'b1;
    uturn   = 1'b0;
    tcmd    = cmd_q;
    tl      = '0;
    tr      = '0;
    unique case (cmd_q)
      CMD_STOP: ;
      CMD_FWD: begin
        tl = mx_s;
        tr = mx_s;
      end
      CMD_BACK: begin
        tl = -smax_q;
        tr = -smax_q;
      end
      CMD_TURN_L: begin
        if (backing) begin
          tcmd = CMD_TREV_L;
          tr   = -mx_s;
        end else begin
          tr   = mx_s;
        end
      end
      CMD_TURN_R: begin
        if (backing) begin
          tcmd = CMD_TREV_R;
          tl   = -mx_s;
        end else begin
          tl   = mx_s;
        end
      end
      CMD_FWD_L: begin
        tl = slow_q;
        tr = mx_s;
      end
      CMD_FWD_R: begin
        tl = mx_s;
        tr = slow_q;
      end
      CMD_BACK_L: begin
        tl = -sslow_q;
        tr = -smax_q;
      end
      CMD_BACK_R: begin
        tl = -smax_q;
        tr = -sslow_q;
      end
      CMD_ROT_L: begin
        tl = -smax_q;
        tr = smax_q;
      end
      CMD_ROT_R: begin
        tl = smax_q;
        tr = -smax_q;
      end
      CMD_UT_L: begin
        uturn = 1'b1;
        tl    = -sslow_q;
        tr    = sslow_q;
      end
      CMD_UT_R: begin
        uturn = 1'b1;
        tl    = sslow_q;
        tr    = -sslow_q;
      end
      default: known = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    push_o  = 1'b0;
    move_o  = '0;
    done    = 1'b0;
    lt_d    = lt_q;
    rt_d    = rt_q;
    unique case (state_q)
      S_IDLE: ;
      S_MUL:  state_d = S_DIV;
      S_DIV:  state_d = S_PLAN;
      S_PLAN: begin
        if (func_q) begin
          // immediate zero drive, flagged with imm
          move_o.cmd   = CMD_STOP;
          move_o.lp    = plan_ramp(9'sd0, 9'sd0, 8'd0);
          move_o.rp    = plan_ramp(9'sd0, 9'sd0, 8'd0);
          move_o.hold  = 16'd0;
          move_o.imm   = 1'b1;
          if (!full_i) begin
            push_o  = 1'b1;
            lt_d    = '0;
            rt_d    = '0;
            state_d = S_PLAN2;
          end
        end else if (known) begin
          move_o.cmd  = tcmd;
          move_o.lp   = plan_ramp(lt_q, tl, min_speed_i);
          move_o.rp   = plan_ramp(rt_q, tr, min_speed_i);
          move_o.hold = uturn ? ut_hold : 16'd1;
          move_o.last = !uturn;
          if (!full_i) begin
            push_o = 1'b1;
            lt_d   = tl;
            rt_d   = tr;
            if (uturn) begin
              state_d = S_PLAN2;
            end else begin
              done = 1'b1;
            end
          end
        end else begin
          // unplanned code: drop
          done = 1'b1;
        end
      end
      S_PLAN2: begin
        move_o.last = 1'b1;
        if (func_q) begin
          move_o.cmd  = CMD_STOP;
          move_o.lp   = plan_ramp(9'sd0, 9'sd0, 8'd0);
          move_o.rp   = plan_ramp(9'sd0, 9'sd0, 8'd0);
          move_o.hold = ESTOP_HOLD;
        end else begin
          move_o.cmd  = CMD_FWD_SLOW;
          move_o.lp   = plan_ramp(lt_q, sslow_q, min_speed_i);
          move_o.rp   = plan_ramp(rt_q, sslow_q, min_speed_i);
          move_o.hold = 16'd1;
        end
        if (!full_i) begin
          push_o = 1'b1;
          done   = 1'b1;
          if (!func_q) begin
            lt_d = sslow_q;
            rt_d = sslow_q;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (done) state_d = S_IDLE;
  end

  // take the next command in the cycle the current one finishes
  assign in_ready_o = (state_q == S_IDLE) || done;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lt_q    <= '0;
      rt_q    <= '0;
    end else begin
      state_q <= accept ? S_MUL : state_d;
      lt_q    <= lt_d;
      rt_q    <= rt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      cmd_q  <= drive_command_i;
      pct_q  <= tick_percent_i;
      run_q  <= running_command_i;
    end
    if (state_q == S_MUL) begin
      prod_q  <= prod_d;
      slow_q  <= slow_d[8:0];
      smax_q  <= smax_d[8:0];
      sslow_q <= sslow_d[8:0];
    end
    if (state_q == S_DIV) begin
      quo_q <= recip_prod[RECIP_SH+15:RECIP_SH];
      neg_q <= prod_q[23];
    end
  end

endmodule

// File: hw/rtl/mssp_queue.sv
// ----------------------------------------------------------------------------
// mssp_queue
// Short FIFO of planned moves between the planner front and the step emitter.
// ----------------------------------------------------------------------------
module mssp_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mssp_pkg::move_t move_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output mssp_pkg::move_t head_o
);
  import mssp_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  move_t         mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      if (pop_i)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= move_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("move pushed into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("move popped from empty queue");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == CW'(DEPTH)) |-> wr_q == rd_q)
    else $error("queue pointers disagree with fill count");

endmodule

// File: hw/rtl/mssp_back.sv
// ----------------------------------------------------------------------------
// mssp_back
// Walks the head move step by step, merging the left and right ramps, and
// presents one speed step per cycle, when not stalled, via an output register.
// ----------------------------------------------------------------------------
module mssp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  mssp_pkg::move_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [4:0]      step_command_o,
  output logic [8:0]      left_speed_o,
  output logic [8:0]      right_speed_o,
  output logic [15:0]     hold_ticks_o,
  output logic            immediate_o,
  output logic            last_o
);
  import mssp_pkg::*;

  logic [STEP_IDX_W-1:0] idx_q, li, ri;
  logic [STEP_CNT_W-1:0] steps;
  logic                  load, final_step;
  logic                  o_valid_q;
  logic [4:0]            o_cmd_q;
  logic [8:0]            o_left_q, o_right_q;
  logic [15:0]           o_hold_q;
  logic                  o_imm_q, o_last_q;

  always_comb begin
    steps      = (head_i.lp.cnt > head_i.rp.cnt) ? head_i.lp.cnt : head_i.rp.cnt;
    final_step = (STEP_CNT_W'(idx_q) == steps - STEP_CNT_W'(1));
    // a shorter ramp holds its last speed
    li = (STEP_CNT_W'(idx_q) < head_i.lp.cnt) ? idx_q
       : STEP_IDX_W'(head_i.lp.cnt - STEP_CNT_W'(1));
    ri = (STEP_CNT_W'(idx_q) < head_i.rp.cnt) ? idx_q
       : STEP_IDX_W'(head_i.rp.cnt - STEP_CNT_W'(1));
    load  = !empty_i && (!o_valid_q || out_ready_i);
    pop_o = load && final_step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
      idx_q     <= '0;
    end else begin
      if (load) begin
        o_valid_q <= 1'b1;
        idx_q     <= final_step ? '0 : idx_q + STEP_IDX_W'(1);
      end else if (out_ready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      o_cmd_q   <= head_i.cmd;
      o_left_q  <= head_i.lp.spd[li];
      o_right_q <= head_i.rp.spd[ri];
      o_hold_q  <= final_step ? head_i.hold : 16'd1;
      o_imm_q   <= head_i.imm;
      o_last_q  <= head_i.last && final_step;
    end
  end

  assign out_valid_o    = o_valid_q;
  assign step_command_o = o_cmd_q;
  assign left_speed_o   = o_left_q;
  assign right_speed_o  = o_right_q;
  assign hold_ticks_o   = o_hold_q;
  assign immediate_o    = o_imm_q;
  assign last_o         = o_last_q;

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> STEP_CNT_W'(idx_q) < steps) else $error("step index past move end");
  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_i |-> idx_q == '0) else $error("step index left mid-move");
  a_imm_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && o_imm_q) |-> (o_hold_q == 16'd0 && !o_last_q))
    else $error("immediate step with hold or last");

endmodule

// File: hw/rtl/motor_speed_step_planner.sv
// ----------------------------------------------------------------------------
// motor_speed_step_planner
// Plans signed left/right motor speed ramps for drive commands.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command: tuser is func (1 = emergency stop), tdata
//   holds drive_command, tick_percent and running_command. m_axis returns the
//   speed steps of that command, one per cycle unless m_axis stalls, tlast on
//   the final one and tuser set on an immediate (queue flushing) step.
//   cfg_we_i writes register cfg_idx_i (0 min_speed, 1 max_speed,
//   2 U-turn base ticks) from cfg_data_i; write only while the block is idle.
//   Unknown codes give none. A command passes S_MUL, S_DIV and S_PLAN, then
//   the move queue and the output register before its first step shows.
//   Throughput: the front plans one command at a time and takes the next as
//   it finishes (U-turns and emergency stops plan two moves); the back emits
//   up to 8 steps per command, one per cycle while m_axis_tready is high.
//   A QUEUE_DEPTH move queue sits between the two.
//   Reset clears both motor targets, empties the queue and loads the register
//   defaults. A stalled receiver holds the output step; the queue fills and
//   then the input stalls.
// ----------------------------------------------------------------------------
module motor_speed_step_planner #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [11:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] drive_command, [15:5] tick_percent, [20:16] running_command
  input  logic [23:0] s_axis_tdata,
  // [0] func
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] step_command, [13:5] left_speed, [22:14] right_speed,
  // [38:23] hold_ticks
  output logic [39:0] m_axis_tdata,
  // [0] immediate
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);
  import mssp_pkg::*;

  logic [7:0]  min_speed_q, max_speed_q;
  logic [11:0] uturn_base_q;
  logic        push, pop, full, empty;
  move_t       push_move, head_move;
  logic [4:0]  step_command;
  logic [8:0]  left_speed, right_speed;
  logic [15:0] hold_ticks;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_speed_q  <= 8'd0;
      max_speed_q  <= 8'd255;
      uturn_base_q <= 12'd100;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MIN_SPEED:  min_speed_q  <= cfg_data_i[7:0];
        REG_MAX_SPEED:  max_speed_q  <= cfg_data_i[7:0];
        REG_UTURN_BASE: uturn_base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mssp_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .min_speed_i       (min_speed_q),
    .max_speed_i       (max_speed_q),
    .uturn_base_i      (uturn_base_q),
    .in_valid_i        (s_axis_tvalid),
    .in_ready_o        (s_axis_tready),
    .func_i            (s_axis_tuser),
    .drive_command_i   (s_axis_tdata[4:0]),
    .tick_percent_i    ($signed(s_axis_tdata[15:5])),
    .running_command_i (s_axis_tdata[20:16]),
    .full_i            (full),
    .push_o            (push),
    .move_o            (push_move)
  );

  mssp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .move_i  (push_move),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head_move)
  );

  mssp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .head_i         (head_move),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .step_command_o (step_command),
    .left_speed_o   (left_speed),
    .right_speed_o  (right_speed),
    .hold_ticks_o   (hold_ticks),
    .immediate_o    (m_axis_tuser),
    .last_o         (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, hold_ticks, right_speed, left_speed, step_command};

endmodule
